@@ sv/isf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package isf_pkg;
  localparam int Depth = 1024;
  localparam int AddrW = 10;
  localparam int LenW = 11;
  localparam int ValW = 32;
  localparam int DiffW = ValW + 1;
  localparam int NumW = DiffW + AddrW;

  // item kinds on the input channel
  localparam logic KindWrite = 1'b0;
  localparam logic KindQuery = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_LOW, ST_RD_HIGH, ST_CHECK, ST_DIV, ST_RD_PROBE, ST_PROBE,
    ST_BIN, ST_RD_MID, ST_MID, ST_RD_FINAL, ST_FINAL, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctrl_t;
endpackage
`default_nettype wire

@@ sv/isf_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface isf_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic [isf_pkg::AddrW-1:0] address;
  logic signed [isf_pkg::ValW-1:0] value;
  logic signed [isf_pkg::ValW-1:0] target;
  modport source (output valid, kind, address, value, target, input ready);
  modport sink (input valid, kind, address, value, target, output ready);
endinterface

interface isf_out_if;
  logic valid;
  logic ready;
  logic found;
  logic [isf_pkg::AddrW-1:0] match_index;
  logic [isf_pkg::LenW-1:0] ins_pos;
  modport source (output valid, found, match_index, ins_pos, input ready);
  modport sink (input valid, found, match_index, ins_pos, output ready);
endinterface
`default_nettype wire

@@ sv/interpolation_search_first_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// write transfers can follow back to back
// a query holds ready low until its result transfer; each interpolation probe passes
// through the low, high and check reads, the serial divider, the probe read and compare
// each binary step runs BIN, RD_MID and MID, the closing read BIN, RD_FINAL and FINAL; length zero answers next cycle
// only one item in flight; the table has a single port and is read one word a cycle
// rst clears the control state and len_cfg; table contents stay undefined
module interpolation_search_first_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [isf_pkg::LenW-1:0] cfg_wdata,
  isf_in_if.sink  in_ch,
  isf_out_if.source out_ch
);
  isf_pkg::state_t state, state_next;
  logic [isf_pkg::ValW-1:0] mem [isf_pkg::Depth];
  logic signed [isf_pkg::ValW-1:0] rd;
  logic [isf_pkg::AddrW-1:0] raddr;
  logic rd_en;
  logic [isf_pkg::LenW-1:0] len_cfg, len, low, high, from, lo, hi, probe;
  logic signed [isf_pkg::ValW-1:0] t, lv, hv;
  logic found;
  logic [isf_pkg::AddrW-1:0] midx;
  logic [isf_pkg::LenW-1:0] ip;
  logic [isf_pkg::NumW-1:0] num, quot;
  logic [isf_pkg::DiffW-1:0] den, tdiff;
  isf_pkg::div_ctrl_t dctl;
  logic div_go;
  logic [isf_pkg::LenW-1:0] mid;
  logic [isf_pkg::LenW:0] psum;
  logic win_ok;

  // single port table, registered read
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready && in_ch.kind == isf_pkg::KindWrite)
      mem[in_ch.address] <= in_ch.value;
    else if (rd_en) rd <= mem[raddr];
  end

  assign len = (len_cfg > isf_pkg::LenW'(isf_pkg::Depth)) ? isf_pkg::LenW'(isf_pkg::Depth)
                                                         : len_cfg;
  assign mid = lo + ((hi - lo) >> 1);
  assign psum = {1'b0, low} + (quot[isf_pkg::NumW-1:isf_pkg::LenW] != '0 ?
                {1'b0, high} : {1'b0, quot[isf_pkg::LenW-1:0]});
  // the high end value is the read that returns in the check cycle
  assign hv = rd;
  assign win_ok = (low <= high) && (lv <= t) && (t <= hv);
  // divider operands, only used when the window holds the target
  assign tdiff = {t[isf_pkg::ValW-1], t} - {lv[isf_pkg::ValW-1], lv};
  assign den = {hv[isf_pkg::ValW-1], hv} - {lv[isf_pkg::ValW-1], lv};
  assign num = isf_pkg::NumW'(tdiff) * isf_pkg::NumW'(high - low);
  assign in_ch.ready = (state == isf_pkg::ST_IDLE);
  assign out_ch.valid = (state == isf_pkg::ST_OUT);
  assign out_ch.found = found;
  assign out_ch.match_index = midx;
  assign out_ch.ins_pos = ip;

  isf_div u_div (.clk(clk), .rst(rst), .start(div_go), .num(num), .den(den),
                 .ctrl(dctl), .quot(quot));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      isf_pkg::ST_IDLE:
        if (in_ch.valid && in_ch.kind == isf_pkg::KindQuery)
          state_next = (len == '0) ? isf_pkg::ST_OUT : isf_pkg::ST_RD_LOW;
      isf_pkg::ST_RD_LOW:   state_next = isf_pkg::ST_RD_HIGH;
      isf_pkg::ST_RD_HIGH:  state_next = isf_pkg::ST_CHECK;
      isf_pkg::ST_CHECK:
        if (!win_ok) state_next = isf_pkg::ST_BIN;
        else if (lv == hv) state_next = isf_pkg::ST_OUT;
        else state_next = isf_pkg::ST_DIV;
      isf_pkg::ST_DIV:      if (dctl.done) state_next = isf_pkg::ST_RD_PROBE;
      isf_pkg::ST_RD_PROBE: state_next = isf_pkg::ST_PROBE;
      isf_pkg::ST_PROBE:
        if (rd < t) state_next = (probe + 1'b1 > high) ? isf_pkg::ST_BIN
                                                       : isf_pkg::ST_RD_LOW;
        else if (rd == t) state_next = isf_pkg::ST_BIN;
        else state_next = isf_pkg::ST_RD_LOW;
      isf_pkg::ST_BIN:
        state_next = (lo < hi) ? isf_pkg::ST_RD_MID : isf_pkg::ST_RD_FINAL;
      isf_pkg::ST_RD_MID:   state_next = isf_pkg::ST_MID;
      isf_pkg::ST_MID:      state_next = isf_pkg::ST_BIN;
      isf_pkg::ST_RD_FINAL: state_next = isf_pkg::ST_FINAL;
      isf_pkg::ST_FINAL:    state_next = isf_pkg::ST_OUT;
      isf_pkg::ST_OUT:      if (out_ch.ready) state_next = isf_pkg::ST_IDLE;
      default:              state_next = isf_pkg::ST_IDLE;
    endcase
  end

  // table read address and divider launch
  always_comb begin
    rd_en = 1'b1;
    raddr = '0;
    div_go = 1'b0;
    unique case (state)
      isf_pkg::ST_RD_LOW:   raddr = low[isf_pkg::AddrW-1:0];
      isf_pkg::ST_RD_HIGH:  raddr = high[isf_pkg::AddrW-1:0];
      isf_pkg::ST_RD_PROBE: raddr = probe[isf_pkg::AddrW-1:0];
      isf_pkg::ST_RD_MID:   raddr = mid[isf_pkg::AddrW-1:0];
      isf_pkg::ST_RD_FINAL: raddr = lo[isf_pkg::AddrW-1:0];
      isf_pkg::ST_CHECK:    div_go = win_ok && (lv != hv);
      default:              rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= isf_pkg::ST_IDLE;
      len_cfg <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) len_cfg <= cfg_wdata;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      isf_pkg::ST_IDLE: begin
        t <= in_ch.target;
        low <= '0;
        high <= len - 1'b1;
        from <= '0;
        found <= 1'b0;
        midx <= '0;
        ip <= '0;
      end
      isf_pkg::ST_RD_HIGH: lv <= rd;
      isf_pkg::ST_CHECK: begin
        if (win_ok && lv == hv) begin
          ip <= low;
          found <= (lv == t);
          midx <= (lv == t) ? low[isf_pkg::AddrW-1:0] : '0;
        end
        lo <= from;
        hi <= (high >= from) ? high + 1'b1 : len;
      end
      isf_pkg::ST_DIV:
        probe <= (psum > {1'b0, high}) ? high : psum[isf_pkg::LenW-1:0];
      isf_pkg::ST_PROBE: begin
        if (rd < t) begin
          low <= probe + 1'b1;
          from <= probe + 1'b1;
          lo <= probe + 1'b1;
          hi <= (high >= probe + 1'b1) ? high + 1'b1 : len;
        end else begin
          high <= probe;
          lo <= from;
          hi <= probe + 1'b1;
        end
      end
      isf_pkg::ST_MID:
        if (rd < t) lo <= mid + 1'b1;
        else hi <= mid;
      isf_pkg::ST_FINAL: begin
        ip <= lo;
        found <= (lo < len) && (rd == t);
        midx <= ((lo < len) && (rd == t)) ? lo[isf_pkg::AddrW-1:0] : '0;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

@@ sv/isf_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit a cycle
module isf_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [isf_pkg::NumW-1:0] num,
  input  wire logic [isf_pkg::DiffW-1:0] den,
  output isf_pkg::div_ctrl_t ctrl,
  output logic [isf_pkg::NumW-1:0] quot
);
  logic [isf_pkg::NumW-1:0] rem_q;
  logic [isf_pkg::DiffW-1:0] dv;
  logic [5:0] cnt;
  logic busy, done;
  logic [isf_pkg::DiffW:0] trial;

  assign trial = {rem_q[isf_pkg::DiffW-1:0], quot[isf_pkg::NumW-1]} - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'(isf_pkg::NumW);
        quot <= num;
        rem_q <= '0;
        dv <= den;
      end else if (busy) begin
        if (!trial[isf_pkg::DiffW]) begin
          rem_q <= isf_pkg::NumW'(trial[isf_pkg::DiffW-1:0]);
          quot <= {quot[isf_pkg::NumW-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[isf_pkg::NumW-2:0], quot[isf_pkg::NumW-1]};
          quot <= {quot[isf_pkg::NumW-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign ctrl = '{start: start, busy: busy, done: done};
endmodule
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb;
  localparam int CycleLimit = 10_000_000;

  typedef struct packed {
    logic found;
    logic [isf_pkg::AddrW-1:0] match_index;
    logic [isf_pkg::LenW-1:0] ins_pos;
  } search_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [isf_pkg::LenW-1:0] cfg_wdata = '0;

  isf_in_if in_ch ();
  isf_out_if out_ch ();

  interpolation_search_first_top i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  // golden copy of the table and the length register
  logic signed [isf_pkg::ValW-1:0] golden_table [isf_pkg::Depth];
  logic [isf_pkg::LenW-1:0] golden_len;
  search_result_t pending_results [$];

  int err_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // free-running clock, 20 ns period
  initial begin
    forever #10 clk = ~clk;
  end

  // watchdog: a hung handshake must not keep the run alive for ever
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // binary lower bound over [lo, hi) of the golden table
  function automatic int lower_bound(int lo, int hi, longint t);
    int mid;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (longint'(golden_table[mid]) < t) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // interpolation probes then lower-bound finish, as the block walks it
  function automatic search_result_t predict_search(logic signed [isf_pkg::ValW-1:0] target);
    search_result_t r;
    int len, low, high, from, probe, ip;
    longint t, lv, hv;
    logic [63:0] num, den;
    r = '0;
    len = (golden_len > isf_pkg::Depth) ? isf_pkg::Depth : golden_len;
    if (len == 0) return r;
    t = target;
    low = 0;
    high = len - 1;
    from = 0;
    while (low <= high && longint'(golden_table[low]) <= t
           && t <= longint'(golden_table[high])) begin
      lv = golden_table[low];
      hv = golden_table[high];
      // equal end values: finish at once on the low end
      if (lv == hv) begin
        r.ins_pos = isf_pkg::LenW'(low);
        if (lv == t) begin
          r.found = 1'b1;
          r.match_index = isf_pkg::AddrW'(low);
        end
        return r;
      end
      num = 64'(t - lv) * 64'(high - low);
      den = 64'(hv - lv);
      probe = low + int'(num / den);
      if (probe > high) probe = high;
      if (longint'(golden_table[probe]) < t) begin
        low = probe + 1;
        from = low;
      end else begin
        high = probe;
        if (longint'(golden_table[probe]) == t) break;
      end
    end
    ip = lower_bound(from, (high >= from) ? high + 1 : len, t);
    r.ins_pos = isf_pkg::LenW'(ip);
    if (ip < len && longint'(golden_table[ip]) == t) begin
      r.found = 1'b1;
      r.match_index = isf_pkg::AddrW'(ip);
    end
    return r;
  endfunction

  // one input transfer, driven on the falling edge with random gaps;
  // valid stays up after the transfer until the next item or an idle cycle
  task automatic send_item(logic kind, logic [isf_pkg::AddrW-1:0] addr,
                           logic signed [isf_pkg::ValW-1:0] val,
                           logic signed [isf_pkg::ValW-1:0] tgt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.address <= addr;
    in_ch.value <= val;
    in_ch.target <= tgt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // transfer accepted here: update golden state or queue the prediction
    if (kind == isf_pkg::KindWrite) golden_table[addr] = val;
    else pending_results.push_back(predict_search(tgt));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    // a trailing write may still be in progress
    repeat (8) @(negedge clk);
  endtask

  task automatic write_length(int len);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= isf_pkg::LenW'(len);
    golden_len = isf_pkg::LenW'(len);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // fill [0, n) with a sorted sequence; mode picks the spread of values
  task automatic fill_sorted(int n, int mode);
    longint v;
    longint step;
    v = (mode == 2) ? -64'sd2147483648 : longint'($urandom_range(2000)) - 64'sd1000;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: step = $urandom_range(3);                // dense, many duplicates
        1: step = $urandom_range(200000);           // sparse
        default: step = 64'sd4294967295 / longint'((n > 1) ? n - 1 : 1);
      endcase
      if (i > 0) v = v + step;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      send_item(isf_pkg::KindWrite, isf_pkg::AddrW'(i), isf_pkg::ValW'(v), '0);
    end
  endtask

  // target drawn mostly from the table, sometimes near or outside it
  function automatic logic signed [isf_pkg::ValW-1:0] pick_target(int n);
    longint b;
    b = golden_table[$urandom_range(n - 1)];
    case ($urandom_range(9))
      0: return isf_pkg::ValW'($urandom);
      1: return 32'sh8000_0000;
      2: return 32'sh7fff_ffff;
      3, 4: begin
        b = b + $signed($urandom_range(4)) - 2;
        if (b > 64'sd2147483647) b = 64'sd2147483647;
        if (b < -64'sd2147483648) b = -64'sd2147483648;
        return isf_pkg::ValW'(b);
      end
      default: return isf_pkg::ValW'(b);
    endcase
  endfunction

  // result checker: every output transfer against the oldest prediction
  always @(posedge clk) begin
    search_result_t exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no query outstanding");
        err_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.found !== exp_r.found) begin
          $error("found: expected %0d got %0d", exp_r.found, out_ch.found);
          err_count++;
        end
        if (out_ch.match_index !== exp_r.match_index) begin
          $error("match_index: expected %0d got %0d", exp_r.match_index,
                 out_ch.match_index);
          err_count++;
        end
        if (out_ch.ins_pos !== exp_r.ins_pos) begin
          $error("ins_pos: expected %0d got %0d", exp_r.ins_pos,
                 out_ch.ins_pos);
          err_count++;
        end
      end
    end
  end

  // receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // empty table, then extremes of length and values
  task automatic test_directed();
    write_length(0);
    send_item(isf_pkg::KindQuery, '0, '0, 32'sh8000_0000);
    send_item(isf_pkg::KindQuery, '0, '0, 32'sh7fff_ffff);
    // single entry, queried at both value extremes
    send_item(isf_pkg::KindWrite, '0, 32'sh8000_0000, '0);
    write_length(1);
    send_item(isf_pkg::KindQuery, '0, '0, 32'sh8000_0000);
    send_item(isf_pkg::KindQuery, '0, '0, 32'sh7fff_ffff);
    // full range spread across the whole table, maximum length
    fill_sorted(isf_pkg::Depth, 2);
    write_length(isf_pkg::Depth);
    send_item(isf_pkg::KindQuery, '0, '0, 32'sh8000_0000);
    send_item(isf_pkg::KindQuery, '0, '0, 32'sh7fff_ffff);
    send_item(isf_pkg::KindQuery, '0, '0, 32'sh0000_0000);
    send_item(isf_pkg::KindQuery, '0, '0, 32'sh5555_5555);
    send_item(isf_pkg::KindQuery, '0, '0, 32'shAAAA_AAAA);
    // length above depth saturates
    write_length(2047);
    send_item(isf_pkg::KindQuery, '0, '0, 32'sh7fff_0000);
    // equal end values: constant run
    for (int i = 0; i < 4; i++)
      send_item(isf_pkg::KindWrite, isf_pkg::AddrW'(i), 32'sd7, '0);
    write_length(4);
    send_item(isf_pkg::KindQuery, '0, '0, 32'sd7);
    send_item(isf_pkg::KindQuery, '0, '0, 32'sd6);
    // unsorted table still terminates
    send_item(isf_pkg::KindWrite, 10'd1, 32'sd100, '0);
    send_item(isf_pkg::KindWrite, 10'd2, -32'sd5, '0);
    send_item(isf_pkg::KindQuery, '0, '0, 32'sd7);
    send_item(isf_pkg::KindQuery, '0, '0, -32'sd5);
    // top address written
    send_item(isf_pkg::KindWrite, 10'd1023, 32'sh7fff_ffff, '0);
  endtask

  // random sorted tables of mostly small lengths, random queries against them;
  // every item sent counts towards the budget
  task automatic test_random(int n_items);
    int sent, n, mode;
    sent = 0;
    while (sent < n_items) begin
      n = ($urandom_range(15) == 0) ? $urandom_range(64, 128)
                                    : $urandom_range(2, 24);
      mode = $urandom_range(2);
      // idle between tables before reprogramming the length
      write_length(0);
      fill_sorted(n, mode);
      sent += n;
      write_length(n);
      for (int q = 0; q < 12; q++) begin
        send_item(isf_pkg::KindQuery, isf_pkg::AddrW'($urandom),
                  isf_pkg::ValW'($urandom), pick_target(n));
        sent++;
      end
      // a write beyond the length and a shrunk length, once per table
      send_item(isf_pkg::KindWrite, isf_pkg::AddrW'($urandom_range(n, isf_pkg::Depth - 1)),
                isf_pkg::ValW'($urandom), '0);
      sent++;
      write_length($urandom_range(1, n));
      for (int q = 0; q < 3; q++) begin
        send_item(isf_pkg::KindQuery, '0, '0, pick_target(golden_len));
        sent++;
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = isf_pkg::KindWrite;
    in_ch.address = '0;
    in_ch.value = '0;
    in_ch.target = '0;
    out_ch.ready = 1'b0;
    golden_len = '0;
    foreach (golden_table[i]) golden_table[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    // sender paused until every result is back
    wait_drained();
    test_random(200);
    send_idle_pct = 77;
    test_random(120);
    send_idle_pct = 0;
    recv_stall_pct = 77;
    test_random(120);
    send_idle_pct = 7;
    recv_stall_pct = 7;
    test_random(120);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(120);

    wait_drained();
    repeat (200) @(negedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
